/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the whole-word occurrence counter.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define WWOC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define WWOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wwoc_pkg.sv */
// Package for the whole-word occurrence counter: types, constants and
// the character-class function. No dependencies.
`default_nettype none

package wwoc_pkg;

  // Parameter defaults
  localparam int KEY_MAX_BYTES_DEF = 8;
  localparam int COUNT_BITS_DEF    = 24;

  // Fixed field widths
  localparam int TEXT_W      = 8;
  localparam int LEN_W       = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int OUT_COUNT_W = 24;

  // Saturation points of the small text counters
  localparam logic [LEN_W-1:0] SEEN_SAT  = 4'd15;
  localparam logic [LEN_W-1:0] SINCE_SAT = 4'd9;

  // Configuration register indexes
  typedef enum logic {
    CFG_KEYWORD_BYTES  = 1'b0,
    CFG_KEYWORD_LENGTH = 1'b1
  } cfg_reg_t;

  // Per-cell status handed to the match logic
  typedef struct packed {
    logic key_eq;
    logic alnum;
  } cell_flags_t;

  // One result word
  typedef struct packed {
    logic                   last;
    logic                   confirmed;
    logic [OUT_COUNT_W-1:0] count;
  } result_t;

  // ASCII letter or digit
  function automatic logic is_alnum(input logic [TEXT_W-1:0] c);
    return c inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]};
  endfunction

endpackage

`default_nettype wire

/* rtl/whole_word_occurrence_count_core.sv */
// Whole-word keyword occurrence counter, top level.
// Result word is registered in the output buffer: the main register, or the skid register when the output stalls.
// Throughput: one text byte per cycle while the skid register is empty (in_tready is low while it holds a word);
// the row of window cells compares all keyword positions in the accepting cycle, with a two-deep output buffer.
// Reset (rst_n low, synchronous): text state and count cleared, keyword regs zero.
// Uses wwoc_pkg, wwoc_cell and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module whole_word_occurrence_count_core #(
  parameter int KEY_MAX_BYTES = wwoc_pkg::KEY_MAX_BYTES_DEF,
  parameter int COUNT_BITS    = wwoc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // text input
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [wwoc_pkg::TEXT_W-1:0]      in_tdata,   // [7:0] text_byte
  input  wire logic                             in_tlast,   // last_byte
  // result output
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [wwoc_pkg::OUT_COUNT_W-1:0]      out_tdata,  // [23:0] occurrence_count
  output logic                                  out_tuser,  // [0] match_confirmed
  output logic                                  out_tlast,  // end_of_text
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire wwoc_pkg::cfg_reg_t               cfg_index,
  input  wire logic [wwoc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wwoc_pkg::*;

  localparam int DEPTH    = KEY_MAX_BYTES + 1;
  localparam int KEY_BITS = 8 * KEY_MAX_BYTES;
  localparam int SEL_W    = $clog2(DEPTH);
  localparam int CNT_KEEP = (COUNT_BITS < OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration registers
  logic [KEY_BITS-1:0] keyword_bytes_r;
  logic [LEN_W-1:0]    keyword_length_r;

  // Text state
  logic [LEN_W-1:0]      seen_r, seen_nxt;
  logic [LEN_W-1:0]      since_r, since_nxt;
  logic                  pending_r, pending_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  // Output buffer
  result_t main_r, main_nxt, skid_r, skid_nxt;
  logic    main_v_r, main_v_nxt, skid_v_r, skid_v_nxt;

  logic in_acc;
  logic [LEN_W-1:0] len_c;

  // Cell row signals
  logic [TEXT_W-1:0] win_d   [DEPTH];
  logic [TEXT_W-1:0] win_q   [DEPTH];
  logic [TEXT_W-1:0] key_sel [DEPTH];
  logic [DEPTH-1:0]  active_v;
  logic [DEPTH-1:0]  eq_v;
  logic [DEPTH-1:0]  alnum_v;
  cell_flags_t       flags   [DEPTH];

  // Match datapath
  logic [LEN_W-1:0]      since_a, since_b, seen_b;
  logic                  conf_pend, conf_last, cand, before_alnum;
  logic [COUNT_BITS:0]   count_sum;
  logic [COUNT_BITS-1:0] count_new;
  result_t               res;

  assign in_tready = !skid_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyword_bytes_r  <= '0;
      keyword_length_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEYWORD_BYTES:  keyword_bytes_r  <= cfg_data[KEY_BITS-1:0];
        CFG_KEYWORD_LENGTH: keyword_length_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Keyword length clamped to KEY_MAX_BYTES
  assign len_c = (keyword_length_r > LEN_W'(KEY_MAX_BYTES)) ?
                 LEN_W'(KEY_MAX_BYTES) : keyword_length_r;

  // Cell i sees the i-th newest byte, matched against keyword byte len-1-i
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      key_sel[i]  = '0;
      active_v[i] = (LEN_W'(i) < len_c);
      for (int j = 0; j < KEY_MAX_BYTES; j++) begin
        if (j + i + 1 == int'(len_c)) key_sel[i] = keyword_bytes_r[8*j +: 8];
      end
    end
  end

  // Row of window cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign win_d[i] = in_tdata;
    end else begin : g_body
      assign win_d[i] = win_q[i-1];
    end

    wwoc_cell u_cell (
      .clk      (clk),
      .shift_en (in_acc),
      .d        (win_d[i]),
      .key      (key_sel[i]),
      .active   (active_v[i]),
      .q        (win_q[i]),
      .flags    (flags[i])
    );

    assign eq_v[i]    = flags[i].key_eq;
    assign alnum_v[i] = flags[i].alnum;
  end

  // Candidate check and count update
  always_comb begin
    conf_pend    = pending_r && !alnum_v[0];
    since_a      = conf_pend ? '0 : since_r;
    since_b      = (since_a < SINCE_SAT) ? since_a + LEN_W'(1) : since_a;
    seen_b       = (seen_r < SEEN_SAT) ? seen_r + LEN_W'(1) : seen_r;
    before_alnum = alnum_v[len_c[SEL_W-1:0]];
    cand = (len_c != '0) && (seen_b >= len_c) && (since_b >= len_c) && (&eq_v) &&
           ((seen_b == len_c) || !before_alnum);
    conf_last = cand && in_tlast;

    count_sum = {1'b0, count_r} + (COUNT_BITS+1)'(conf_pend) + (COUNT_BITS+1)'(conf_last);
    count_new = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[COUNT_BITS-1:0];

    res.count     = OUT_COUNT_W'(count_new[CNT_KEEP-1:0]);
    res.confirmed = conf_pend || conf_last;
    res.last      = in_tlast;
  end

  // Text state next value; end of text returns everything to reset
  always_comb begin
    seen_nxt    = seen_r;
    since_nxt   = since_r;
    pending_nxt = pending_r;
    count_nxt   = count_r;
    if (in_acc) begin
      if (in_tlast) begin
        seen_nxt    = '0;
        since_nxt   = SINCE_SAT;
        pending_nxt = 1'b0;
        count_nxt   = '0;
      end else begin
        seen_nxt    = seen_b;
        since_nxt   = since_b;
        pending_nxt = cand;
        count_nxt   = count_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      since_r   <= SINCE_SAT;
      pending_r <= 1'b0;
      count_r   <= '0;
    end else begin
      seen_r    <= seen_nxt;
      since_r   <= since_nxt;
      pending_r <= pending_nxt;
      count_r   <= count_nxt;
    end
  end

  // Output register with skid stage
  always_comb begin
    main_nxt   = main_r;
    main_v_nxt = main_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (!main_v_r || out_tready) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = res;
        main_v_nxt = in_acc;
      end
    end else if (in_acc) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  assign out_tvalid = main_v_r;
  assign out_tdata  = main_r.count;
  assign out_tuser  = main_r.confirmed;
  assign out_tlast  = main_r.last;

  // Checks
  `WWOC_ASSERT(a_skid_behind_main, !skid_v_r || main_v_r, "skid word without output word")
  `WWOC_ASSERT_NEXT(a_last_clears, in_acc && in_tlast,
    !pending_r && (count_r == '0) && (seen_r == '0), "text state not cleared after last word")
  `WWOC_ASSERT(a_fresh_text, (seen_r != '0) || ((since_r == SINCE_SAT) && !pending_r),
    "fresh text with stale match state")

endmodule

`default_nettype wire

/* rtl/wwoc_cell.sv */
// One window cell: holds one recent text byte, compares the byte it is
// about to load against its keyword byte. Depends on wwoc_pkg.
`default_nettype none

module wwoc_cell (
  input  wire logic                         clk,
  input  wire logic                         shift_en,
  input  wire logic [wwoc_pkg::TEXT_W-1:0]  d,
  input  wire logic [wwoc_pkg::TEXT_W-1:0]  key,
  input  wire logic                         active,
  output logic      [wwoc_pkg::TEXT_W-1:0]  q,
  output wwoc_pkg::cell_flags_t             flags
);
  import wwoc_pkg::*;

  logic [TEXT_W-1:0] q_r;
  logic [TEXT_W-1:0] q_nxt;

  // Shift stage: take the input byte (head cell) or the neighbor's byte on every accepted word
  always_comb begin
    q_nxt = shift_en ? d : q_r;
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

  // Status of the incoming byte; an inactive cell never blocks a match
  always_comb begin
    flags.key_eq = !active || (d == key);
    flags.alnum  = is_alnum(d);
  end

endmodule

`default_nettype wire
